// ===== rtl/mono_bitmap_rect_fill_defines.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the monochrome rectangle fill block
// Concurrent checks clocked on clk; empty when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef MONO_BITMAP_RECT_FILL_DEFINES_SVH
`define MONO_BITMAP_RECT_FILL_DEFINES_SVH

`ifndef SYNTHESIS
// check that is switched off while rst_n is low
`define MBRF_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// check that also holds during reset
`define MBRF_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MBRF_ASSERT(lbl, prop, msg)
`define MBRF_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== rtl/mbrf_pkg.sv =====
// ---------------------------------------------------------------------------
// mbrf_pkg
// Command codes and the item and result bundles shared by the fill block.
// ---------------------------------------------------------------------------
`default_nettype none

package mbrf_pkg;

    typedef enum logic [1:0] {
        CMD_FILL  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_READ  = 2'd2,
        CMD_NOP   = 2'd3
    } cmd_t;

    typedef struct packed {
        cmd_t        command;
        logic [7:0]  left_x;
        logic [7:0]  top_y;
        logic [7:0]  rect_width;
        logic [7:0]  rect_height;
        logic        fill_colour;
        logic [4:0]  byte_column;
        logic [7:0]  write_data;
    } cmd_item_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       status;
    } res_t;

    typedef struct packed {
        logic idle;       // ready for the next item
        logic res_valid;  // result waiting for the output register
    } ctrl_stat_t;

endpackage

`default_nettype wire

// ===== rtl/mbrf_mem.sv =====
// ---------------------------------------------------------------------------
// mbrf_mem
// Frame store: one write port, one read port, registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module mbrf_mem #(
    parameter int DEPTH = 3200,
    parameter int AW    = 12
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [7:0]    wdata,
    input  wire logic [AW-1:0] raddr,
    output logic      [7:0]    rdata
);

    logic [7:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/mbrf_ctrl.sv =====
// ---------------------------------------------------------------------------
// mbrf_ctrl
// Command sequencer: clearing pass, byte write and read, and the pipelined
// read-modify-write walk over the bytes of a clipped fill rectangle.
// ---------------------------------------------------------------------------
`default_nettype none

module mbrf_ctrl import mbrf_pkg::*; #(
    parameter int ROW_BYTES   = 20,
    parameter int SCREEN_ROWS = 160,
    parameter int AW          = 12
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          graphics_mode,
    input  wire logic          item_valid,
    input  wire cmd_item_t     item,
    input  wire logic          res_ready,
    output ctrl_stat_t         stat,
    output res_t               res,
    output logic               mem_we,
    output logic [AW-1:0]      mem_waddr,
    output logic [7:0]         mem_wdata,
    output logic [AW-1:0]      mem_raddr,
    input  wire logic [7:0]    mem_rdata
);

    localparam int STORE = ROW_BYTES * SCREEN_ROWS;
    localparam int COLS  = ROW_BYTES * 8;
    localparam int XW    = $clog2(COLS + 512);
    localparam int YW    = $clog2(SCREEN_ROWS + 512);
    localparam int BW    = $clog2(ROW_BYTES + 1);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PREP,
        ST_FILL,
        ST_RDWAIT,
        ST_DONE
    } state_t;

    state_t          state_reg,     state_next;
    logic [AW-1:0]   clr_addr_reg,  clr_addr_next;
    cmd_item_t       item_reg,      item_next;
    res_t            res_reg,       res_next;
    logic [AW-1:0]   row_base_reg,  row_base_next;
    logic [BW-1:0]   b_reg,         b_next;
    logic [BW-1:0]   b0_reg,        b0_next;
    logic [BW-1:0]   b1_reg,        b1_next;
    logic [2:0]      lo0_reg,       lo0_next;
    logic [2:0]      hi1_reg,       hi1_next;
    logic [YW-1:0]   rows_left_reg, rows_left_next;
    logic            rd_inside_reg, rd_inside_next;
    logic            wr_pend_reg,   wr_pend_next;
    logic [AW-1:0]   wr_addr_reg,   wr_addr_next;
    logic [7:0]      wr_mask_reg,   wr_mask_next;

    // accept-time address of a byte write or read
    logic            in_store;
    logic [AW-1:0]   idx_in;

    // clipping of the latched fill
    logic [XW-1:0]   x0, xs, x1, xl;
    logic [YW-1:0]   y0, ys, y1;
    logic            empty;
    logic [AW-1:0]   base_y;

    // current byte of the walk
    logic [AW-1:0]   fill_addr;
    logic [2:0]      lo, hi;
    logic [7:0]      mask;

    function automatic logic [7:0] edge_mask(input logic [2:0] lo_bit, input logic [2:0] hi_bit);
        edge_mask = (8'hFF >> lo_bit) & (8'hFF << (3'd7 - hi_bit));
    endfunction

    always_comb
    begin
        in_store = (YW'(item.top_y) < YW'(SCREEN_ROWS))
                && ({4'd0, item.byte_column} < 9'(ROW_BYTES));
        idx_in = AW'(item.top_y) * AW'(ROW_BYTES) + AW'(item.byte_column);

        x0     = XW'(item_reg.left_x);
        xs     = x0 + XW'(item_reg.rect_width);
        x1     = (xs < XW'(COLS)) ? xs : XW'(COLS);
        xl     = x1 - XW'(1);
        y0     = YW'(item_reg.top_y);
        ys     = y0 + YW'(item_reg.rect_height);
        y1     = (ys < YW'(SCREEN_ROWS)) ? ys : YW'(SCREEN_ROWS);
        empty  = (item_reg.rect_width == 8'd0) || (item_reg.rect_height == 8'd0)
              || (x0 >= XW'(COLS)) || (y0 >= YW'(SCREEN_ROWS));
        base_y = AW'(item_reg.top_y) * AW'(ROW_BYTES);

        fill_addr = row_base_reg + AW'(b_reg);
        lo        = (b_reg == b0_reg) ? lo0_reg : 3'd0;
        hi        = (b_reg == b1_reg) ? hi1_reg : 3'd7;
        mask      = edge_mask(lo, hi);
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_addr_next  = clr_addr_reg;
        item_next      = item_reg;
        res_next       = res_reg;
        row_base_next  = row_base_reg;
        b_next         = b_reg;
        b0_next        = b0_reg;
        b1_next        = b1_reg;
        lo0_next       = lo0_reg;
        hi1_next       = hi1_reg;
        rows_left_next = rows_left_reg;
        rd_inside_next = rd_inside_reg;
        wr_pend_next   = 1'b0;
        wr_addr_next   = wr_addr_reg;
        wr_mask_next   = wr_mask_reg;

        mem_raddr = fill_addr;
        mem_we    = wr_pend_reg;
        mem_waddr = wr_addr_reg;
        if (item_reg.fill_colour)
        begin
            mem_wdata = mem_rdata | wr_mask_reg;
        end
        else
        begin
            mem_wdata = mem_rdata & ~wr_mask_reg;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                mem_we        = 1'b1;
                mem_waddr     = clr_addr_reg;
                mem_wdata     = 8'd0;
                clr_addr_next = clr_addr_reg + AW'(1);
                if (clr_addr_reg == AW'(STORE - 1))
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (item_valid)
                begin
                    item_next = item;
                    res_next  = '0;
                    case (item.command)
                        CMD_FILL:
                        begin
                            if (graphics_mode)
                            begin
                                res_next.status = 1'b1;
                                state_next      = ST_DONE;
                            end
                            else
                            begin
                                state_next = ST_PREP;
                            end
                        end
                        CMD_WRITE:
                        begin
                            mem_we     = in_store;
                            mem_waddr  = idx_in;
                            mem_wdata  = item.write_data;
                            state_next = ST_DONE;
                        end
                        CMD_READ:
                        begin
                            mem_raddr      = idx_in;
                            rd_inside_next = in_store;
                            state_next     = ST_RDWAIT;
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end

            ST_PREP:
            begin
                row_base_next  = base_y;
                b0_next        = x0[BW+2:3];
                b_next         = x0[BW+2:3];
                b1_next        = xl[BW+2:3];
                lo0_next       = x0[2:0];
                hi1_next       = xl[2:0];
                rows_left_next = y1 - y0;
                state_next     = empty ? ST_DONE : ST_FILL;
            end

            ST_FILL:
            begin
                // read this byte now, merge and write it back next cycle
                wr_pend_next = 1'b1;
                wr_addr_next = fill_addr;
                wr_mask_next = mask;
                if (b_reg == b1_reg)
                begin
                    b_next         = b0_reg;
                    row_base_next  = row_base_reg + AW'(ROW_BYTES);
                    rows_left_next = rows_left_reg - YW'(1);
                    if (rows_left_reg == YW'(1))
                    begin
                        state_next = ST_DONE;
                    end
                end
                else
                begin
                    b_next = b_reg + BW'(1);
                end
            end

            ST_RDWAIT:
            begin
                res_next.read_data = rd_inside_reg ? mem_rdata : 8'd0;
                state_next         = ST_DONE;
            end

            ST_DONE:
            begin
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            item_reg      <= '0;
            res_reg       <= '0;
            row_base_reg  <= '0;
            b_reg         <= '0;
            b0_reg        <= '0;
            b1_reg        <= '0;
            lo0_reg       <= '0;
            hi1_reg       <= '0;
            rows_left_reg <= '0;
            rd_inside_reg <= 1'b0;
            wr_pend_reg   <= 1'b0;
            wr_addr_reg   <= '0;
            wr_mask_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            item_reg      <= item_next;
            res_reg       <= res_next;
            row_base_reg  <= row_base_next;
            b_reg         <= b_next;
            b0_reg        <= b0_next;
            b1_reg        <= b1_next;
            lo0_reg       <= lo0_next;
            hi1_reg       <= hi1_next;
            rows_left_reg <= rows_left_next;
            rd_inside_reg <= rd_inside_next;
            wr_pend_reg   <= wr_pend_next;
            wr_addr_reg   <= wr_addr_next;
            wr_mask_reg   <= wr_mask_next;
        end
    end

    assign stat.idle      = (state_reg == ST_IDLE);
    assign stat.res_valid = (state_reg == ST_DONE);
    assign res            = res_reg;

endmodule

`default_nettype wire

// ===== rtl/mono_bitmap_rect_fill.sv =====
// ---------------------------------------------------------------------------
// mono_bitmap_rect_fill
// One-bit frame store of SCREEN_ROWS rows of ROW_BYTES bytes with rectangle
// fill, byte write and byte read commands.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one command item; output
//   channel (out_valid / out_stall) returns one item per command with
//   read_data and status. cfg_write loads graphics_mode from cfg_data; the
//   user must write it only while the block is idle, which the block does
//   not enforce. With it set, fills are dropped and return status 1. After
//   reset the ROW_BYTES*SCREEN_ROWS bytes of the store (3200 at the
//   defaults) are cleared one byte per cycle, with in_stall high until the
//   clear is done. A byte write, dropped fill or unused code goes straight
//   to the done state, a read first waits for the registered read data, and
//   a fill passes a prep state and walks the clipped bytes row by row. The
//   fill walk does one read-modify-write byte per cycle, paced by the single
//   read port of the frame store. One item is in work at a time; the next
//   item is accepted while a finished result still waits in the output
//   register. When the receiver stalls, the output item holds, and a second
//   finished result waits in the sequencer, which then takes no new item.
// ---------------------------------------------------------------------------
`default_nettype none

`include "mono_bitmap_rect_fill_defines.svh"

module mono_bitmap_rect_fill import mbrf_pkg::*; #(
    parameter int ROW_BYTES   = 20,
    parameter int SCREEN_ROWS = 160
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_write,
    input  wire logic       cfg_data,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [1:0] command,
    input  wire logic [7:0] left_x,
    input  wire logic [7:0] top_y,
    input  wire logic [7:0] rect_width,
    input  wire logic [7:0] rect_height,
    input  wire logic       fill_colour,
    input  wire logic [4:0] byte_column,
    input  wire logic [7:0] write_data,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [7:0]      read_data,
    output logic            status
);

    localparam int STORE = ROW_BYTES * SCREEN_ROWS;
    localparam int AW    = (STORE > 1) ? $clog2(STORE) : 1;

    logic            graphics_mode_reg;
    logic            out_valid_reg, out_valid_next;
    res_t            out_res_reg,   out_res_next;

    cmd_item_t       item;
    ctrl_stat_t      ctrl_stat;
    res_t            ctrl_res;
    logic            res_ready;

    logic            mem_we;
    logic [AW-1:0]   mem_waddr;
    logic [7:0]      mem_wdata;
    logic [AW-1:0]   mem_raddr;
    logic [7:0]      mem_rdata;

    always_comb
    begin
        item.command     = cmd_t'(command);
        item.left_x      = left_x;
        item.top_y       = top_y;
        item.rect_width  = rect_width;
        item.rect_height = rect_height;
        item.fill_colour = fill_colour;
        item.byte_column = byte_column;
        item.write_data  = write_data;
    end

    assign in_stall  = !ctrl_stat.idle;
    assign res_ready = !out_valid_reg || !out_stall;

    mbrf_ctrl #(
        .ROW_BYTES   (ROW_BYTES),
        .SCREEN_ROWS (SCREEN_ROWS),
        .AW          (AW)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .graphics_mode (graphics_mode_reg),
        .item_valid    (in_valid),
        .item          (item),
        .res_ready     (res_ready),
        .stat          (ctrl_stat),
        .res           (ctrl_res),
        .mem_we        (mem_we),
        .mem_waddr     (mem_waddr),
        .mem_wdata     (mem_wdata),
        .mem_raddr     (mem_raddr),
        .mem_rdata     (mem_rdata)
    );

    mbrf_mem #(
        .DEPTH (STORE),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_res_next   = out_res_reg;
        if (ctrl_stat.res_valid && res_ready)
        begin
            out_valid_next = 1'b1;
            out_res_next   = ctrl_res;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            graphics_mode_reg <= 1'b0;
            out_valid_reg     <= 1'b0;
            out_res_reg       <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                graphics_mode_reg <= cfg_data;
            end
            out_valid_reg <= out_valid_next;
            out_res_reg   <= out_res_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign read_data = out_res_reg.read_data;
    assign status    = out_res_reg.status;

    `MBRF_ASSERT(a_idle_no_result, ctrl_stat.idle |-> !ctrl_stat.res_valid, "result pending while idle")
    `MBRF_ASSERT(a_result_held, ctrl_stat.res_valid && out_valid_reg && out_stall |=> ctrl_stat.res_valid, "result dropped while output full")
    `MBRF_ASSERT(a_load_on_free, ctrl_stat.res_valid && res_ready |=> out_valid_reg, "result taken but output empty")
    `MBRF_ASSERT_ALWAYS(a_status_no_data, out_valid && status |-> read_data == 8'd0, "flagged fill carries read data")

endmodule

`default_nettype wire

// ===== verif/mbrf_fill_checker.sv =====
// ---------------------------------------------------------------------------
// mbrf_fill_checker
// Watches the command and result channels of the rectangle fill block, keeps
// its own copy of the frame store and graphics mode, and compares each
// result item with the one predicted for the oldest outstanding command.
// ---------------------------------------------------------------------------
module mbrf_fill_checker import mbrf_pkg::*; #(
    parameter int ROW_BYTES   = 20,
    parameter int SCREEN_ROWS = 160
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_write,
    input  logic       cfg_data,
    input  logic       in_valid,
    input  logic       in_stall,
    input  logic [1:0] command,
    input  logic [7:0] left_x,
    input  logic [7:0] top_y,
    input  logic [7:0] rect_width,
    input  logic [7:0] rect_height,
    input  logic       fill_colour,
    input  logic [4:0] byte_column,
    input  logic [7:0] write_data,
    input  logic       out_valid,
    input  logic       out_stall,
    input  logic [7:0] read_data,
    input  logic       status,
    output int         errors,
    output int         pending,
    output int         checked
);

    localparam int unsigned STORE_BYTES = ROW_BYTES * SCREEN_ROWS;
    localparam int unsigned SCREEN_COLS = ROW_BYTES * 8;

    logic [7:0] pixel_bytes [STORE_BYTES];
    logic       graphics_on;
    res_t       awaited_results [$];

    function automatic void fill_rectangle(input int unsigned x0, input int unsigned y0,
                                           input int unsigned w, input int unsigned h,
                                           input logic colour);
        int unsigned x_end;
        int unsigned y_end;
        int unsigned row;
        int unsigned col;
        int unsigned lo;
        int unsigned hi;
        int unsigned addr;
        logic [7:0]  mask;
        if (w == 0 || h == 0 || x0 >= SCREEN_COLS || y0 >= SCREEN_ROWS)
            return;
        x_end = (x0 + w < SCREEN_COLS) ? x0 + w : SCREEN_COLS;
        y_end = (y0 + h < SCREEN_ROWS) ? y0 + h : SCREEN_ROWS;
        for (row = y0; row < y_end; row++)
        begin
            for (col = x0 >> 3; col <= ((x_end - 1) >> 3); col++)
            begin
                // pixel span inside this byte, bit 7 is the leftmost pixel
                lo   = (x0 > col * 8) ? x0 - col * 8 : 0;
                hi   = (x_end - 1 < col * 8 + 7) ? x_end - 1 - col * 8 : 7;
                mask = (8'hFF >> lo) & (8'hFF << (7 - hi));
                addr = row * ROW_BYTES + col;
                if (colour)
                    pixel_bytes[addr] = pixel_bytes[addr] | mask;
                else
                    pixel_bytes[addr] = pixel_bytes[addr] & ~mask;
            end
        end
    endfunction

    function automatic res_t predict_result();
        res_t        want;
        logic        in_store;
        int unsigned addr;
        want     = '0;
        in_store = (top_y < SCREEN_ROWS) && (byte_column < ROW_BYTES);
        addr     = top_y * ROW_BYTES + byte_column;
        case (cmd_t'(command))
            CMD_FILL:
                if (graphics_on)
                    want.status = 1'b1;
                else
                    fill_rectangle(left_x, top_y, rect_width, rect_height, fill_colour);
            CMD_WRITE:
                if (in_store)
                    pixel_bytes[addr] = write_data;
            CMD_READ:
                if (in_store)
                    want.read_data = pixel_bytes[addr];
            default: ;
        endcase
        return want;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        res_t want;
        int   bad;
        bad = 0;
        if (!rst_n)
        begin
            foreach (pixel_bytes[i])
                pixel_bytes[i] = 8'h00;
            graphics_on = 1'b0;
            awaited_results.delete();
            errors  <= 0;
            pending <= 0;
            checked <= 0;
        end
        else
        begin
            if (cfg_write)
                graphics_on = cfg_data;
            if (out_valid && !out_stall)
            begin
                if (awaited_results.size() == 0)
                begin
                    $display("%0t: result item with none outstanding: read_data %02h status %0d",
                             $time, read_data, status);
                    bad++;
                end
                else
                begin
                    want = awaited_results.pop_front();
                    if (read_data !== want.read_data)
                    begin
                        $display("%0t: read_data expected %02h actual %02h",
                                 $time, want.read_data, read_data);
                        bad++;
                    end
                    if (status !== want.status)
                    begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, status);
                        bad++;
                    end
                    checked <= checked + 1;
                end
            end
            if (in_valid && !in_stall)
                awaited_results.push_back(predict_result());
            pending <= awaited_results.size();
            errors  <= errors + bad;
        end
    end

endmodule

// ===== verif/tb.sv =====
// ---------------------------------------------------------------------------
// tb
// Drives the rectangle fill block with directed edge cases and then bursts
// of random fills, byte writes, reads and unused-code items under both
// graphics modes, with random sender gaps and receiver stalls; the checker
// beside the block predicts and compares every result item.
// ---------------------------------------------------------------------------
module tb;
    import mbrf_pkg::*;

    localparam int ROW_BYTES   = 20;
    localparam int SCREEN_ROWS = 160;
    // the limit covers a normal run, including the store clear after reset
    // and the full-screen and occasional large fills
    localparam int unsigned CYCLE_LIMIT = 2_000_000;

    logic       clk;
    logic       rst_n;
    logic       cfg_write;
    logic       cfg_data;
    logic       in_valid;
    logic       in_stall;
    logic [1:0] command;
    logic [7:0] left_x;
    logic [7:0] top_y;
    logic [7:0] rect_width;
    logic [7:0] rect_height;
    logic       fill_colour;
    logic [4:0] byte_column;
    logic [7:0] write_data;
    logic       out_valid;
    logic       out_stall;
    logic [7:0] read_data;
    logic       status;

    int          errors;
    int          pending;
    int          checked;
    int unsigned cycle_count;
    int unsigned burst_left;
    int unsigned sent_by_cmd [4];

    mono_bitmap_rect_fill #(
        .ROW_BYTES   (ROW_BYTES),
        .SCREEN_ROWS (SCREEN_ROWS)
    ) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .command     (command),
        .left_x      (left_x),
        .top_y       (top_y),
        .rect_width  (rect_width),
        .rect_height (rect_height),
        .fill_colour (fill_colour),
        .byte_column (byte_column),
        .write_data  (write_data),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .read_data   (read_data),
        .status      (status)
    );

    mbrf_fill_checker #(
        .ROW_BYTES   (ROW_BYTES),
        .SCREEN_ROWS (SCREEN_ROWS)
    ) u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .command     (command),
        .left_x      (left_x),
        .top_y       (top_y),
        .rect_width  (rect_width),
        .rect_height (rect_height),
        .fill_colour (fill_colour),
        .byte_column (byte_column),
        .write_data  (write_data),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .read_data   (read_data),
        .status      (status),
        .errors      (errors),
        .pending     (pending),
        .checked     (checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
        $display("CHECK FAILED");
        $finish;
    end

    // receiver: stretches of no stall, scattered stalls, or long stalls
    initial
    begin
        int unsigned stretch;
        int unsigned style;
        int unsigned hold;
        logic        stall_now;
        logic        long_on;
        long_on   = 1'b1;
        out_stall <= 1'b0;
        @(posedge clk);
        forever
        begin
            stretch = $urandom_range(400, 40);
            style   = $urandom_range(2, 0);
            while (stretch > 0)
            begin
                case (style)
                    0:
                    begin
                        stall_now = 1'b0;
                        hold      = 1;
                    end
                    1:
                    begin
                        stall_now = ($urandom_range(2, 0) == 0);
                        hold      = 1;
                    end
                    default:
                    begin
                        stall_now = long_on;
                        hold      = long_on ? $urandom_range(40, 4) : $urandom_range(4, 1);
                        long_on   = !long_on;
                    end
                endcase
                out_stall <= stall_now;
                repeat (hold) @(posedge clk);
                stretch = (hold >= stretch) ? 0 : stretch - hold;
            end
        end
    end

    // sender bursts; a gap of zero keeps valid high across the burst boundary
    task automatic pace_sender();
        int unsigned gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(40, 1);
            gap = ($urandom_range(9, 0) < 3) ? 0 : $urandom_range(12, 1);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
    endtask

    task automatic send_item(input cmd_item_t it);
        pace_sender();
        in_valid    <= 1'b1;
        command     <= it.command;
        left_x      <= it.left_x;
        top_y       <= it.top_y;
        rect_width  <= it.rect_width;
        rect_height <= it.rect_height;
        fill_colour <= it.fill_colour;
        byte_column <= it.byte_column;
        write_data  <= it.write_data;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sent_by_cmd[it.command]++;
    endtask

    task automatic send_fields(input cmd_t cmd, input logic [7:0] x, input logic [7:0] y,
                               input logic [7:0] w, input logic [7:0] h, input logic colour,
                               input logic [4:0] col, input logic [7:0] data);
        cmd_item_t it;
        it = '{cmd, x, y, w, h, colour, col, data};
        send_item(it);
    endtask

    // hold the sender until every outstanding result has come back
    task automatic drain();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    task automatic set_graphics_mode(input logic mode);
        drain();
        cfg_data  <= mode;
        cfg_write <= 1'b1;
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    function automatic cmd_item_t random_item(input int unsigned serial);
        cmd_item_t   it;
        int unsigned pick;
        int unsigned spot;
        it.command     = CMD_NOP;
        it.left_x      = $urandom_range(255, 0);
        it.top_y       = $urandom_range(255, 0);
        it.rect_width  = $urandom_range(255, 0);
        it.rect_height = $urandom_range(255, 0);
        it.fill_colour = $urandom_range(1, 0);
        it.byte_column = $urandom_range(31, 0);
        it.write_data  = $urandom_range(255, 0);
        pick = $urandom_range(99, 0);
        spot = $urandom_range(9, 0);
        if (serial % 100 == 50)
        begin
            // occasional large fill, up to the whole screen
            it.command = CMD_FILL;
            it.left_x  = $urandom_range(159, 0);
            it.top_y   = $urandom_range(159, 0);
        end
        else if (pick < 35)
        begin
            it.command     = CMD_FILL;
            it.left_x      = (spot < 5) ? $urandom_range(31, 0) : $urandom_range(159, 0);
            it.top_y       = (spot < 5) ? $urandom_range(15, 0) : $urandom_range(159, 0);
            it.rect_width  = $urandom_range(24, 1);
            it.rect_height = $urandom_range(12, 1);
        end
        else if (pick < 90)
        begin
            it.command = (pick < 60) ? CMD_WRITE : CMD_READ;
            if (spot < 5)
            begin
                it.top_y       = $urandom_range(15, 0);
                it.byte_column = $urandom_range(3, 0);
            end
            else if (spot < 9)
            begin
                it.top_y       = $urandom_range(159, 0);
                it.byte_column = $urandom_range(19, 0);
            end
            // otherwise keep the full-range address, often off the store
        end
        else if (pick < 95)
        begin
            // fill hanging over the right edge, any size and row
            it.command = CMD_FILL;
            it.left_x  = $urandom_range(255, 144);
        end
        return it;
    endfunction

    initial
    begin
        int unsigned phase_items [5];
        logic        phase_mode  [5];
        int unsigned serial;
        int unsigned n;
        phase_items = '{400, 200, 350, 150, 300};
        phase_mode  = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
        burst_left  = 0;
        serial      = 0;
        foreach (sent_by_cmd[i])
            sent_by_cmd[i] = 0;

        rst_n       <= 1'b0;
        cfg_write   <= 1'b0;
        cfg_data    <= 1'b0;
        in_valid    <= 1'b0;
        command     <= CMD_NOP;
        left_x      <= 8'd0;
        top_y       <= 8'd0;
        rect_width  <= 8'd0;
        rect_height <= 8'd0;
        fill_colour <= 1'b0;
        byte_column <= 5'd0;
        write_data  <= 8'd0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        // the store clear after reset holds the input stalled
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        set_graphics_mode(1'b0);

        send_fields(CMD_READ,    0,   0,   0,   0, 0,  0, 8'h00);
        send_fields(CMD_FILL,    0,   0, 160, 160, 1,  0, 8'h00);
        send_fields(CMD_READ,    0, 159,   0,   0, 0, 19, 8'h00);
        send_fields(CMD_FILL,    3,   5,  10,   2, 0,  0, 8'h00);
        send_fields(CMD_READ,    0,   6,   0,   0, 0,  0, 8'h00);
        send_fields(CMD_READ,    0,   6,   0,   0, 0,  1, 8'h00);
        send_fields(CMD_FILL,  157, 159,   1,   1, 0,  0, 8'h00);
        send_fields(CMD_FILL,  150, 150, 255, 255, 0,  0, 8'h00);
        send_fields(CMD_READ,    0, 159,   0,   0, 0, 18, 8'h00);
        send_fields(CMD_FILL,  200,   0,  10,  10, 0,  0, 8'h00);
        send_fields(CMD_FILL,    0, 255,  10,  10, 0,  0, 8'h00);
        send_fields(CMD_FILL,    0,   0,   0,  10, 0,  0, 8'h00);
        send_fields(CMD_FILL,    0,   0,  10,   0, 0,  0, 8'h00);
        send_fields(CMD_WRITE,   0,   0,   0,   0, 0,  0, 8'hA5);
        send_fields(CMD_WRITE,   0, 160,   0,   0, 0,  0, 8'h5A);
        send_fields(CMD_WRITE,   0, 255,   0,   0, 0, 31, 8'hFF);
        send_fields(CMD_READ,    0,   0,   0,   0, 0,  0, 8'h00);
        send_fields(CMD_READ,    0,   0,   0,   0, 0, 20, 8'h00);
        send_fields(CMD_READ,    0, 160,   0,   0, 0,  0, 8'h00);
        send_fields(CMD_NOP,   255, 255, 255, 255, 1, 31, 8'hFF);
        send_fields(CMD_FILL,    0,   0, 160, 160, 0,  0, 8'h00);

        // graphics mode: fills are dropped, byte access still works
        set_graphics_mode(1'b1);
        send_fields(CMD_FILL,    0,   0, 160, 160, 1,  0, 8'h00);
        send_fields(CMD_WRITE,   0,   2,   0,   0, 0,  3, 8'h3C);
        send_fields(CMD_READ,    0,   2,   0,   0, 0,  3, 8'h00);

        foreach (phase_items[p])
        begin
            set_graphics_mode(phase_mode[p]);
            for (n = 0; n < phase_items[p]; n++)
            begin
                if ($urandom_range(149, 0) == 0)
                    drain();
                send_item(random_item(serial));
                serial++;
            end
        end

        drain();
        repeat (16) @(posedge clk);
        $display("Sent %0d fills, %0d byte writes, %0d byte reads, %0d unused-code items",
                 sent_by_cmd[CMD_FILL], sent_by_cmd[CMD_WRITE], sent_by_cmd[CMD_READ],
                 sent_by_cmd[CMD_NOP]);
        $display("Compared %0d results over %0d cycles, %0d mismatches",
                 checked, cycle_count, errors);
        if (errors == 0 && pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
